/* hdl/spo_pkg.sv */
// ----------------------------------------------------------------------------
// spo_pkg
// Shared types and constants for the shape pair overlap test: shape kinds,
// the ordered-pair control group and the default coordinate width.
// ----------------------------------------------------------------------------
package spo_pkg;

	// default coordinate width (Q12.4 centers)
	localparam int COORD_WIDTH_DEF = 16;
	// stored bits of a packed size field
	localparam int SIZE_WIDTH      = 48;
	// spatial axes
	localparam int AXES            = 3;

	// shape kind codes
	typedef enum logic [1:0] {
		KIND_POINT   = 2'd0,
		KIND_BOX     = 2'd1,
		KIND_SPHERE  = 2'd2,
		KIND_INVALID = 2'd3
	} kind_t;

	// pair after ordering: p has the lower kind code
	typedef struct packed {
		logic  valid;
		kind_t p_kind;
		kind_t q_kind;
	} pair_ctl_t;

endpackage

/* hdl/spo_shape_sel.sv */
// ----------------------------------------------------------------------------
// spo_shape_sel
// Orders the pair by kind, unpacks the size slices and forms the doubled
// absolute center offsets per axis.
// ----------------------------------------------------------------------------
module spo_shape_sel #(
	parameter int COORD_WIDTH = spo_pkg::COORD_WIDTH_DEF
) (
	input  spo_pkg::kind_t                        kind_a,
	input  logic signed [COORD_WIDTH-1:0]          a_x,
	input  logic signed [COORD_WIDTH-1:0]          a_y,
	input  logic signed [COORD_WIDTH-1:0]          a_z,
	input  logic [spo_pkg::SIZE_WIDTH-1:0]         size_a,
	input  spo_pkg::kind_t                        kind_b,
	input  logic signed [COORD_WIDTH-1:0]          b_x,
	input  logic signed [COORD_WIDTH-1:0]          b_y,
	input  logic signed [COORD_WIDTH-1:0]          b_z,
	input  logic [spo_pkg::SIZE_WIDTH-1:0]         size_b,
	output spo_pkg::pair_ctl_t                    ctl,
	output logic [spo_pkg::AXES-1:0][COORD_WIDTH-1:0] p_size,
	output logic [spo_pkg::AXES-1:0][COORD_WIDTH-1:0] q_size,
	output logic [spo_pkg::AXES-1:0][COORD_WIDTH+1:0] d2
);

	logic [spo_pkg::AXES-1:0][COORD_WIDTH-1:0] ca, cb;
	logic [spo_pkg::AXES-1:0][COORD_WIDTH-1:0] sa, sb;
	logic                                      swap;

	assign ca = {a_z, a_y, a_x};
	assign cb = {b_z, b_y, b_x};

	// size slices; bits above the stored field read as zero
	for (genvar k = 0; k < spo_pkg::AXES; k++) begin : g_axis
		for (genvar j = 0; j < COORD_WIDTH; j++) begin : g_bit
			if (k * COORD_WIDTH + j < spo_pkg::SIZE_WIDTH) begin : g_in
				assign sa[k][j] = size_a[k * COORD_WIDTH + j];
				assign sb[k][j] = size_b[k * COORD_WIDTH + j];
			end else begin : g_out
				assign sa[k][j] = 1'b0;
				assign sb[k][j] = 1'b0;
			end
		end

		// |2*(a-b)|, same for either order
		logic signed [COORD_WIDTH:0] diff;
		logic [COORD_WIDTH:0]        mag;
		assign diff = $signed({ca[k][COORD_WIDTH-1], ca[k]})
			- $signed({cb[k][COORD_WIDTH-1], cb[k]});
		assign mag   = diff[COORD_WIDTH] ? (~diff + 1'b1) : diff;
		assign d2[k] = {mag, 1'b0};
	end

	// lower kind code goes to p
	assign swap = (kind_a > kind_b);

	always_comb begin
		ctl.valid  = (kind_a != spo_pkg::KIND_INVALID) && (kind_b != spo_pkg::KIND_INVALID);
		ctl.p_kind = swap ? kind_b : kind_a;
		ctl.q_kind = swap ? kind_a : kind_b;
		p_size     = swap ? sb : sa;
		q_size     = swap ? sa : sb;
	end

endmodule

/* hdl/spo_overlap_core.sv */
// ----------------------------------------------------------------------------
// spo_overlap_core
// Evaluates point-point, box bounds and sphere distance tests on an ordered
// pair and selects the answer by the kind of q.
// ----------------------------------------------------------------------------
module spo_overlap_core #(
	parameter int COORD_WIDTH = spo_pkg::COORD_WIDTH_DEF
) (
	input  spo_pkg::pair_ctl_t                        ctl,
	input  logic [spo_pkg::AXES-1:0][COORD_WIDTH-1:0] p_size,
	input  logic [spo_pkg::AXES-1:0][COORD_WIDTH-1:0] q_size,
	input  logic [spo_pkg::AXES-1:0][COORD_WIDTH+1:0] d2,
	output logic                                      hit
);

	localparam int DW   = COORD_WIDTH + 2;
	localparam int SQW  = 2 * DW;
	localparam int ACCW = SQW + 2;

	logic                                 p_box, p_sph;
	logic [spo_pkg::AXES-1:0]             ax_in;
	logic [spo_pkg::AXES-1:0][SQW-1:0]    sqv;
	logic [COORD_WIDTH:0]                 rsum;
	logic [DW-1:0]                        reach;
	logic [SQW-1:0]                       reach_sq;
	logic [ACCW-1:0]                      acc;
	logic                                 pp_ok, box_ok, sph_ok;

	assign p_box = (ctl.p_kind == spo_pkg::KIND_BOX);
	assign p_sph = (ctl.p_kind == spo_pkg::KIND_SPHERE);

	for (genvar k = 0; k < spo_pkg::AXES; k++) begin : g_axis
		logic [COORD_WIDTH:0] lim;
		logic [DW-1:0]        ps;
		logic [DW-1:0]        e;

		// box bound: doubled offset against summed full sizes
		assign lim = {1'b0, q_size[k]} + (p_box ? {1'b0, p_size[k]} : '0);
		assign ax_in[k] = (d2[k] <= {1'b0, lim});

		// distance outside the box along this axis (clamped center)
		assign ps = {2'b00, p_size[k]};
		assign e  = p_box ? ((d2[k] > ps) ? (d2[k] - ps) : '0) : d2[k];
		assign sqv[k] = {{DW{1'b0}}, e} * {{DW{1'b0}}, e};
	end

	// sphere reach: doubled radius or doubled radius sum
	assign rsum     = {1'b0, q_size[0]} + (p_sph ? {1'b0, p_size[0]} : '0);
	assign reach    = {rsum, 1'b0};
	assign reach_sq = {{DW{1'b0}}, reach} * {{DW{1'b0}}, reach};

	assign acc    = {2'b00, sqv[0]} + {2'b00, sqv[1]} + {2'b00, sqv[2]};
	assign sph_ok = (acc <= {2'b00, reach_sq});
	assign box_ok = &ax_in;
	assign pp_ok  = ~|d2;

	// pick the test by the higher kind
	always_comb begin
		case (ctl.q_kind)
			spo_pkg::KIND_POINT:  hit = ctl.valid && pp_ok;
			spo_pkg::KIND_BOX:    hit = ctl.valid && box_ok;
			spo_pkg::KIND_SPHERE: hit = ctl.valid && sph_ok;
			default:              hit = 1'b0;
		endcase
	end

endmodule

/* hdl/shape_pair_overlap_test.sv */
// ----------------------------------------------------------------------------
// shape_pair_overlap_test
// Overlap test for a pair of shapes (point, axis-aligned box, sphere).
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle; busy is always low.
// Path: input register, order/offset logic, squarers and compare, result reg.
// Reset clears the valid and strobe flags; no result is issued after reset
// until a transaction is accepted. The receiver cannot stall.
module shape_pair_overlap_test #(
	parameter int COORD_WIDTH = spo_pkg::COORD_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         shape_a,
	input  logic signed [COORD_WIDTH-1:0]      a_x,
	input  logic signed [COORD_WIDTH-1:0]      a_y,
	input  logic signed [COORD_WIDTH-1:0]      a_z,
	input  logic [spo_pkg::SIZE_WIDTH-1:0]     size_a,
	input  logic [1:0]                         shape_b,
	input  logic signed [COORD_WIDTH-1:0]      b_x,
	input  logic signed [COORD_WIDTH-1:0]      b_y,
	input  logic signed [COORD_WIDTH-1:0]      b_z,
	input  logic [spo_pkg::SIZE_WIDTH-1:0]     size_b,
	output logic                               done,
	output logic                               hit
);

	logic                                       v_s1;
	spo_pkg::kind_t                             kind_a_s1, kind_b_s1;
	logic signed [COORD_WIDTH-1:0]              ax_s1, ay_s1, az_s1;
	logic signed [COORD_WIDTH-1:0]              bx_s1, by_s1, bz_s1;
	logic [spo_pkg::SIZE_WIDTH-1:0]             size_a_s1, size_b_s1;

	spo_pkg::pair_ctl_t                         ctl;
	logic [spo_pkg::AXES-1:0][COORD_WIDTH-1:0]  p_size, q_size;
	logic [spo_pkg::AXES-1:0][COORD_WIDTH+1:0]  d2;
	logic                                       hit_c;

	logic                                       done_q, hit_q;

	// never stalls
	assign busy = 1'b0;

	// input register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	// input register: payload
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_a_s1 <= spo_pkg::kind_t'(shape_a);
			kind_b_s1 <= spo_pkg::kind_t'(shape_b);
			ax_s1     <= a_x;
			ay_s1     <= a_y;
			az_s1     <= a_z;
			bx_s1     <= b_x;
			by_s1     <= b_y;
			bz_s1     <= b_z;
			size_a_s1 <= size_a;
			size_b_s1 <= size_b;
		end
	end

	spo_shape_sel #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_sel (
		.kind_a (kind_a_s1),
		.a_x    (ax_s1),
		.a_y    (ay_s1),
		.a_z    (az_s1),
		.size_a (size_a_s1),
		.kind_b (kind_b_s1),
		.b_x    (bx_s1),
		.b_y    (by_s1),
		.b_z    (bz_s1),
		.size_b (size_b_s1),
		.ctl    (ctl),
		.p_size (p_size),
		.q_size (q_size),
		.d2     (d2)
	);

	spo_overlap_core #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_core (
		.ctl    (ctl),
		.p_size (p_size),
		.q_size (q_size),
		.d2     (d2),
		.hit    (hit_c)
	);

	// result register; hit reads low between strobes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			done_q <= v_s1;
			hit_q  <= v_s1 && hit_c;
		end
	end

	assign done = done_q;
	assign hit  = hit_q;

	// each accepted transaction yields one strobe, through the input and result registers
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("result strobe missing after accepted transaction");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(v_s1))
		else $error("result strobe without staged transaction");

	a_hit_strobed: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> done)
		else $error("hit raised outside a result strobe");

	a_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && (kind_a_s1 == spo_pkg::KIND_INVALID ||
			kind_b_s1 == spo_pkg::KIND_INVALID)) |=> !hit)
		else $error("hit reported for an invalid shape kind");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (ctl.p_kind <= ctl.q_kind))
		else $error("pair not ordered by kind");

endmodule
